>>> hdl/lmrf_pkg.sv
package lmrf_pkg;

  localparam int unsigned TauW = 6;
  localparam int unsigned PixW = 8;
  localparam int unsigned ColW = 12;

  localparam logic [TauW-1:0] TauReset = 6'd18;

  localparam int unsigned MaxTauDef      = 63;
  localparam int unsigned MaxRowWidthDef = 4096;

endpackage

>>> hdl/lmrf_if.sv
interface lmrf_pix_if;
  import lmrf_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel;
  logic            row_end;

  modport source (output valid, output pixel, output row_end, input ready);
  modport sink (input valid, input pixel, input row_end, output ready);
endinterface

interface lmrf_res_if;
  import lmrf_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] marking;
  logic [ColW-1:0] column;
  logic            last;

  modport source (output valid, output marking, output column, output last, input ready);
  modport sink (input valid, input marking, input column, input last, output ready);
endinterface

>>> hdl/lmrf_ram.sv
module lmrf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/lane_marking_row_filter_core.sv
// Lane marking row filter: takes one gray pixel per clock in raster order
// unless stalled by a flush or the output, and returns 2x - a - b - |a - b|
// clamped to 0..255, where a and b lie tau columns left and right of centre x;
// columns within tau of either row edge give zero. A pixel at column c >= tau
// produces the result for column c - tau via the s1 stage and result register.
// A row_end pixel also produces the remaining edge columns as zeros, one per
// cycle unless the output stalls, holding the input for that flush. Two copies
// of a 2**clog2(2*MaxTau+1) entry history RAM give one read port each for the
// centre and left neighbour; the right neighbour is the incoming pixel.
// The user must write tau via tau_we_i/tau_wdata_i only while idle (unchecked).
module lane_marking_row_filter_core #(
  parameter int unsigned MaxTau      = lmrf_pkg::MaxTauDef,
  parameter int unsigned MaxRowWidth = lmrf_pkg::MaxRowWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      tau_we_i,
  input  logic [lmrf_pkg::TauW-1:0] tau_wdata_i,
  lmrf_pix_if.sink                  pix_i,
  lmrf_res_if.source                res_o
);
  import lmrf_pkg::*;

  localparam int unsigned ColCntW = $clog2(MaxRowWidth);
  localparam int unsigned HistAw  = $clog2(2 * MaxTau + 1);
  localparam int unsigned HistDepth = 2 ** HistAw;
  localparam logic [ColCntW-1:0] ColLast = ColCntW'(MaxRowWidth - 1);
  localparam logic [TauW-1:0]    TauSat  = TauW'(MaxTau);

  logic [TauW-1:0]    tau_q;
  logic [TauW-1:0]    tau_eff;
  logic [ColCntW-1:0] tau_c;

  logic [ColCntW-1:0] col_q, col_d;
  logic               in_xfer;
  logic               has_main;
  logic [ColCntW-1:0] centre;
  logic [HistAw-1:0]  wr_addr, x_addr, a_addr;
  logic [PixW-1:0]    x_rd, a_rd;

  logic               s1_main_q, s1_main_d;
  logic               s1_flush_q, s1_flush_d;
  logic [ColCntW-1:0] s1_fcol_q, s1_fcol_d;
  logic [ColCntW-1:0] s1_end_q;
  logic [ColCntW-1:0] s1_centre_q;
  logic [PixW-1:0]    s1_px_q;
  logic               s1_calc_q;
  logic               s1_last_main_q;

  logic               s1_pending, emit, flush_done, s1_final;
  logic [PixW-1:0]    max_ab;
  logic [PixW:0]      diff;
  logic [PixW-1:0]    strength;
  logic [PixW-1:0]    item_mark;
  logic [ColCntW-1:0] item_col;
  logic               item_last;

  logic               res_valid_q, res_valid_d;
  logic [PixW-1:0]    res_mark_q;
  logic [ColCntW-1:0] res_col_q;
  logic               res_last_q;

  assign tau_eff = (tau_q > TauSat) ? TauSat : tau_q;
  assign tau_c   = ColCntW'(tau_eff);

  assign in_xfer  = pix_i.valid && pix_i.ready;
  assign has_main = col_q >= tau_c;
  assign centre   = col_q - tau_c;
  assign wr_addr  = col_q[HistAw-1:0];
  assign x_addr   = centre[HistAw-1:0];
  assign a_addr   = HistAw'(centre - tau_c);

  lmrf_ram #(
    .Width (PixW),
    .Depth (HistDepth)
  ) u_hist_x (
    .clk_i   (clk_i),
    .we_i    (in_xfer),
    .waddr_i (wr_addr),
    .wdata_i (pix_i.pixel),
    .re_i    (in_xfer),
    .raddr_i (x_addr),
    .rdata_o (x_rd)
  );

  lmrf_ram #(
    .Width (PixW),
    .Depth (HistDepth)
  ) u_hist_a (
    .clk_i   (clk_i),
    .we_i    (in_xfer),
    .waddr_i (wr_addr),
    .wdata_i (pix_i.pixel),
    .re_i    (in_xfer),
    .raddr_i (a_addr),
    .rdata_o (a_rd)
  );

  // 2x - a - b - |a - b| reduces to 2 * (x - max(a, b))
  always_comb begin
    max_ab = (a_rd > s1_px_q) ? a_rd : s1_px_q;
    diff   = {1'b0, x_rd} - {1'b0, max_ab};
    if (x_rd <= max_ab) begin
      strength = '0;
    end else if (diff[PixW-1]) begin
      strength = '1;
    end else begin
      strength = {diff[PixW-2:0], 1'b0};
    end
  end

  assign s1_pending = s1_main_q || s1_flush_q;
  assign emit       = s1_pending && (!res_valid_q || res_o.ready);
  assign flush_done = s1_fcol_q == s1_end_q;
  assign s1_final   = emit && (s1_main_q ? !s1_flush_q : flush_done);
  assign pix_i.ready = !s1_pending || s1_final;

  assign item_mark = (s1_main_q && s1_calc_q) ? strength : '0;
  assign item_col  = s1_main_q ? s1_centre_q : s1_fcol_q;
  assign item_last = s1_main_q ? s1_last_main_q : flush_done;

  always_comb begin
    col_d      = col_q;
    s1_main_d  = s1_main_q;
    s1_flush_d = s1_flush_q;
    s1_fcol_d  = s1_fcol_q;
    if (emit) begin
      if (s1_main_q) begin
        s1_main_d = 1'b0;
      end else begin
        s1_fcol_d = s1_fcol_q + 1'b1;
        if (flush_done) begin
          s1_flush_d = 1'b0;
        end
      end
    end
    if (in_xfer) begin
      s1_main_d  = has_main;
      s1_flush_d = pix_i.row_end && (!has_main || tau_eff != '0);
      s1_fcol_d  = has_main ? centre + 1'b1 : '0;
      if (pix_i.row_end || col_q == ColLast) begin
        col_d = '0;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_comb begin
    if (emit) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tau_q       <= TauReset;
      col_q       <= '0;
      s1_main_q   <= 1'b0;
      s1_flush_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (tau_we_i) begin
        tau_q <= tau_wdata_i;
      end
      col_q       <= col_d;
      s1_main_q   <= s1_main_d;
      s1_flush_q  <= s1_flush_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_fcol_q <= s1_fcol_d;
    if (in_xfer) begin
      s1_end_q       <= col_q;
      s1_centre_q    <= centre;
      s1_px_q        <= pix_i.pixel;
      s1_calc_q      <= (centre >= tau_c) && (tau_eff != '0);
      s1_last_main_q <= pix_i.row_end && (tau_eff == '0);
    end
    if (emit) begin
      res_mark_q <= item_mark;
      res_col_q  <= item_col;
      res_last_q <= item_last;
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.marking = res_mark_q;
  assign res_o.column  = ColW'(res_col_q);
  assign res_o.last    = res_last_q;

endmodule

>>> hdl/lmrf_checker.sv
module lmrf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      pix_ready_i,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic [lmrf_pkg::PixW-1:0] res_marking_i,
  input logic [lmrf_pkg::ColW-1:0] res_column_i,
  input logic                      res_last_i
);
  import lmrf_pkg::*;

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_marking_i)
      && $stable(res_column_i) && $stable(res_last_i))
    else $error("stalled result changed");

  // input stalls only behind a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_ready_i |=> res_valid_i)
    else $error("input stalled with no result moving");

  // row end result is always an edge column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_last_i |-> res_marking_i == '0)
    else $error("nonzero marking on last result");

  assert property (@(posedge clk_i)
    !rst_ni |-> !res_valid_i)
    else $error("result valid during reset");

endmodule

bind lane_marking_row_filter_core lmrf_checker u_lmrf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pix_ready_i   (pix_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_marking_i (res_o.marking),
  .res_column_i  (res_o.column),
  .res_last_i    (res_o.last)
);
